>>> sv/rsl_pkg.sv
// rsl_pkg: types and constants of the run-length slice line generator.
// Used by rsl_front and rsl_back; depends on nothing.
`timescale 1ns / 1ps
package rsl_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_VERT   = 3'd1,
    PH_HORIZ  = 3'd2,
    PH_DIAG   = 3'd3,
    PH_FIRST  = 3'd4,
    PH_MIDDLE = 3'd5,
    PH_FINAL  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    FS_IDLE = 2'd0,
    FS_DIV  = 2'd1,
    FS_PUSH = 2'd2
  } front_e;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

endpackage

>>> sv/rsl_front.sv
// rsl_front: accepts items, shifts and orders endpoints, runs the iterative
// divide for sloped lines and pushes a decoded command into the queue.
// Depends on rsl_pkg.
`timescale 1ns / 1ps
module rsl_front #(
  parameter int CB = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic          func_i,
  input  logic [CB-1:0] x_start_i,
  input  logic [CB-1:0] y_start_i,
  input  logic [CB-1:0] x_end_i,
  input  logic [CB-1:0] y_end_i,
  input  logic [3:0]    intensity_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output logic [CB*5+9:0] cmd_o
);
  // cmd: {adv, ph[2:0], sx, sy, xn, ym, lvl, ws, rem, mnr} packed below
  localparam int CW = CB * 5 + 10;

  rsl_pkg::front_e st_q, st_d;
  logic [CB-1:0] x1_q, y1_q, dx_q, dy_q;
  logic xn_q, adv_q;
  logic [3:0] lvl_q;
  logic [CB-1:0] num_q, mnr_q;
  logic [CB:0]   rem_q;
  logic [$clog2(CB+1)-1:0] cnt_q;
  logic [2:0] ph_q;

  logic [CB-1:0] ax, ay, bx, by, x1, y1, x2, y2, dxr, dx, dy;
  logic sw, xn;
  logic [CB:0] rtry;
  logic [CB:0] ddx;
  logic [CB-1:0] maj, mnr;

  always_comb begin
    ax = x_start_i ^ {1'b1, {(CB-1){1'b0}}};
    ay = y_start_i ^ {1'b1, {(CB-1){1'b0}}};
    bx = x_end_i ^ {1'b1, {(CB-1){1'b0}}};
    by = y_end_i ^ {1'b1, {(CB-1){1'b0}}};
    sw = ay > by;
    x1 = sw ? bx : ax;
    y1 = sw ? by : ay;
    x2 = sw ? ax : bx;
    y2 = sw ? ay : by;
    ddx = {1'b0, x2} - {1'b0, x1};
    xn = ddx[CB];
    dxr = ddx[CB-1:0];
    dx = xn ? (~dxr + 1'b1) : dxr;
    dy = y2 - y1;
    maj = (dy > dx) ? dy : dx;
    mnr = (dy > dx) ? dx : dy;
    rtry = {rem_q[CB-1:0], num_q[CB-1]} - {1'b0, mnr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rsl_pkg::FS_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    ready_o = 1'b0;
    cmd_valid_o = 1'b0;
    unique case (st_q)
      rsl_pkg::FS_IDLE: begin
        ready_o = 1'b1;
        if (valid_i) begin
          if (func_i == rsl_pkg::FUNC_ADVANCE) st_d = rsl_pkg::FS_PUSH;
          else if (dx == '0 || dy == '0 || dx == dy) st_d = rsl_pkg::FS_PUSH;
          else st_d = rsl_pkg::FS_DIV;
        end
      end
      rsl_pkg::FS_DIV: begin
        if (cnt_q == '0) st_d = rsl_pkg::FS_PUSH;
      end
      rsl_pkg::FS_PUSH: begin
        cmd_valid_o = 1'b1;
        if (cmd_ready_i) st_d = rsl_pkg::FS_IDLE;
      end
      default: st_d = rsl_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == rsl_pkg::FS_IDLE && valid_i) begin
      adv_q <= func_i;
      x1_q <= x1;
      y1_q <= y1;
      dx_q <= dx;
      dy_q <= dy;
      xn_q <= xn;
      lvl_q <= intensity_i;
      num_q <= maj;
      mnr_q <= mnr;
      rem_q <= '0;
      cnt_q <= ($clog2(CB+1))'(CB - 1);
      if (dx == '0) ph_q <= 3'(rsl_pkg::PH_VERT);
      else if (dy == '0) ph_q <= 3'(rsl_pkg::PH_HORIZ);
      else if (dx == dy) ph_q <= 3'(rsl_pkg::PH_DIAG);
      else ph_q <= 3'(rsl_pkg::PH_FIRST);
    end else if (st_q == rsl_pkg::FS_DIV) begin
      // restoring divide, one quotient bit a cycle, quotient into num_q
      if (!rtry[CB]) begin
        rem_q <= rtry;
        num_q <= {num_q[CB-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[CB-1:0], num_q[CB-1]};
        num_q <= {num_q[CB-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // for simple lines num_q holds the larger distance, rem_q is unused
  assign cmd_o = CW'({adv_q, ph_q, x1_q, y1_q, xn_q, (dy_q > dx_q), lvl_q,
                      num_q, rem_q[CB-1:0], mnr_q});
endmodule

>>> sv/rsl_queue.sv
// rsl_queue: two-entry queue between the front and back parts.
// Depends on nothing.
`timescale 1ns / 1ps
module rsl_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);
  logic [W-1:0] mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end
endmodule

>>> sv/rsl_back.sv
// rsl_back: holds the line state, steps one point per cycle into an output
// register while advance commands arrive and it is not stalled. Depends on rsl_pkg.
`timescale 1ns / 1ps
module rsl_back #(
  parameter int CB = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  logic [CB*5+9:0] cmd_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [CB-1:0] point_x_o,
  output logic [CB-1:0] point_y_o,
  output logic [3:0]    point_intensity_o,
  output logic          last_point_o
);
  logic c_adv, c_xn, c_ym;
  logic [2:0] c_ph;
  logic [CB-1:0] c_x, c_y, c_ws, c_rem, c_mnr;
  logic [3:0] c_lvl;
  assign {c_adv, c_ph, c_x, c_y, c_xn, c_ym, c_lvl, c_ws, c_rem, c_mnr} = cmd_i;

  rsl_pkg::phase_e ph_q, ph_d;
  logic [CB-1:0] px_q, px_d, py_q, py_d, ws_q, ws_d, rl_q, rl_d, fl_q, fl_d;
  logic xn_q, xn_d, ym_q, ym_d;
  logic [CB:0] ea_q, ea_d, es_q, es_d, rp_q, rp_d;
  logic signed [CB+2:0] acc_q, acc_d;
  logic [3:0] lv_q, lv_d;
  logic ov_q, ov_d;
  logic [CB-1:0] ox_q, oy_q, ox_d, oy_d;
  logic [3:0] ol_q, ol_d;
  logic olast_q, olast_d;

  logic take;
  logic [CB-1:0] ipc, d;
  logic signed [CB+2:0] acc_t;

  assign cmd_ready_o = !ov_q || ready_i;
  assign take = cmd_valid_i && cmd_ready_o;
  assign valid_o = ov_q;
  assign point_x_o = ox_q;
  assign point_y_o = oy_q;
  assign point_intensity_o = ol_q;
  assign last_point_o = olast_q;

  function automatic logic [CB-1:0] stx(input logic [CB-1:0] x, input logic n);
    stx = n ? x - 1'b1 : x + 1'b1;
  endfunction

  always_comb begin
    ph_d = ph_q; px_d = px_q; py_d = py_q; ws_d = ws_q; rl_d = rl_q;
    fl_d = fl_q; xn_d = xn_q; ym_d = ym_q; ea_d = ea_q; es_d = es_q;
    rp_d = rp_q; acc_d = acc_q; lv_d = lv_q;
    ov_d = ov_q && !ready_i;
    ox_d = ox_q; oy_d = oy_q; ol_d = ol_q; olast_d = olast_q;
    ipc = '0; d = '0; acc_t = '0;
    if (take) begin
      if (c_adv == rsl_pkg::FUNC_LOAD) begin
        px_d = c_x; py_d = c_y; xn_d = c_xn; lv_d = c_lvl; ym_d = 1'b0;
        if (c_ph != 3'(rsl_pkg::PH_FIRST)) begin
          d = c_ws;
          if (d <= CB'(1)) begin
            ph_d = rsl_pkg::PH_IDLE; rp_d = '0;
          end else begin
            ph_d = rsl_pkg::phase_e'(c_ph); rp_d = {1'b0, d - 1'b1};
          end
        end else begin
          ym_d = c_ym;
          ws_d = c_ws;
          ea_d = {c_rem, 1'b0};
          es_d = {c_mnr, 1'b0};
          acc_d = $signed({3'b0, c_rem}) - $signed({2'b0, c_mnr, 1'b0})
                  + (c_ws[0] ? $signed({3'b0, c_mnr}) : '0);
          ipc = (c_ws >> 1) + 1'b1;
          fl_d = ipc;
          if (c_rem == '0 && !c_ws[0]) ipc = ipc - 1'b1;
          rl_d = c_mnr - 1'b1;
          ph_d = rsl_pkg::PH_FIRST;
          rp_d = {1'b0, ipc};
          if (ipc == '0) begin
            // empty first run: step minor axis and open the first middle run, or the final run if none
            if (c_ym) px_d = stx(c_x, c_xn);
            else py_d = c_y + 1'b1;
            if (rl_d != '0) begin
              rl_d = rl_d - 1'b1;
              acc_t = acc_d + $signed({2'b0, ea_d});
              rp_d = {1'b0, c_ws};
              if (acc_t > 0) begin
                rp_d = rp_d + 1'b1;
                acc_t = acc_t - $signed({2'b0, es_d});
              end
              acc_d = acc_t;
              ph_d = rsl_pkg::PH_MIDDLE;
            end else begin
              rp_d = {1'b0, fl_d};
              ph_d = rsl_pkg::PH_FINAL;
            end
          end
        end
      end else if (ph_q == rsl_pkg::PH_IDLE || rp_q == '0) begin
        ph_d = rsl_pkg::PH_IDLE;
      end else begin
        ov_d = 1'b1;
        ox_d = px_q; oy_d = py_q; ol_d = lv_q;
        olast_d = (ph_q != rsl_pkg::PH_FIRST && ph_q != rsl_pkg::PH_MIDDLE)
                  && rp_q == (CB+1)'(1);
        rp_d = rp_q - 1'b1;
        if (ph_q == rsl_pkg::PH_VERT || ph_q == rsl_pkg::PH_HORIZ ||
            ph_q == rsl_pkg::PH_DIAG) begin
          if (ph_q != rsl_pkg::PH_VERT) px_d = stx(px_q, xn_q);
          if (ph_q != rsl_pkg::PH_HORIZ) py_d = py_q + 1'b1;
          if (rp_d == '0) ph_d = rsl_pkg::PH_IDLE;
        end else begin
          if (ym_q) py_d = py_q + 1'b1;
          else px_d = stx(px_q, xn_q);
          if (rp_d == '0) begin
            if (ph_q == rsl_pkg::PH_FINAL) begin
              ph_d = rsl_pkg::PH_IDLE;
            end else begin
              if (ym_q) px_d = stx(px_q, xn_q);
              else py_d = py_q + 1'b1;
              if (rl_q != '0) begin
                rl_d = rl_q - 1'b1;
                acc_t = acc_q + $signed({2'b0, ea_q});
                rp_d = {1'b0, ws_q};
                if (acc_t > 0) begin
                  rp_d = rp_d + 1'b1;
                  acc_t = acc_t - $signed({2'b0, es_q});
                end
                acc_d = acc_t;
                ph_d = rsl_pkg::PH_MIDDLE;
              end else begin
                rp_d = {1'b0, fl_q};
                ph_d = rsl_pkg::PH_FINAL;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= rsl_pkg::PH_IDLE;
      px_q <= '0; py_q <= '0; ws_q <= '0; rl_q <= '0; fl_q <= '0;
      xn_q <= 1'b0; ym_q <= 1'b0; ea_q <= '0; es_q <= '0; rp_q <= '0;
      acc_q <= '0; lv_q <= '0; ov_q <= 1'b0;
    end else begin
      ph_q <= ph_d;
      px_q <= px_d; py_q <= py_d; ws_q <= ws_d; rl_q <= rl_d; fl_q <= fl_d;
      xn_q <= xn_d; ym_q <= ym_d; ea_q <= ea_d; es_q <= es_d; rp_q <= rp_d;
      acc_q <= acc_d; lv_q <= lv_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q <= ox_d; oy_q <= oy_d; ol_q <= ol_d; olast_q <= olast_d;
  end
endmodule

>>> sv/run_slice_line_point_generator_unit.sv
// Top level of the run-length slice line point generator.
// Depends on rsl_pkg, rsl_front, rsl_queue, rsl_back.
//
// channel | direction | fields
// in      | input     | func, x_start, y_start, x_end, y_end, intensity
// out     | output    | point_x, point_y, point_intensity, last_point
//
// An advance or simple load takes the front through accept and push; the point
// of an advance goes through the queue into the back's output register.
// A sloped load takes the front through accept, the divide steps of one
// quotient bit each, and the push. Reset clears control.
// The queue lets the front take items while the output register stalls, until its two entries are full.
`timescale 1ns / 1ps
module run_slice_line_point_generator_unit #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic                  func_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  input  logic [3:0]            intensity_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [COORD_BITS-1:0] point_x_o,
  output logic [COORD_BITS-1:0] point_y_o,
  output logic [3:0]            point_intensity_o,
  output logic                  last_point_o
);
  localparam int CW = COORD_BITS * 5 + 10;

  logic f_valid, f_ready, b_valid, b_ready;
  logic [CW-1:0] f_cmd, b_cmd;

  rsl_front #(.CB(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .func_i, .x_start_i, .y_start_i,
    .x_end_i, .y_end_i, .intensity_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  rsl_queue #(.W(CW)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i(f_cmd),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_data_o(b_cmd)
  );

  rsl_back #(.CB(COORD_BITS)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .valid_o, .ready_i, .point_x_o, .point_y_o, .point_intensity_o,
    .last_point_o
  );
endmodule
